[rtl/btc_pkg.sv]
package btc_pkg;

   // Fixed field widths and key packing
   localparam int CHAR_BITS   = 16;
   localparam int LEN_BITS    = 4;
   localparam int ENTRY_BITS  = 3;
   localparam int KEY_SLOTS   = 8;
   localparam int KEY_REGS    = 4;
   localparam int KEY_BITS    = LEN_BITS + ENTRY_BITS * KEY_SLOTS;
   localparam int BUF_DEPTH   = 8;
   localparam int CNT_BITS    = 3;
   localparam int IDX_BITS    = 3;

   localparam logic [LEN_BITS-1:0] MAX_BLOCK_LEN = 4'd8;
   localparam logic [CNT_BITS-1:0] MAX_BLOCKS    = 3'd4;
   localparam logic [LEN_BITS-1:0] FILL_SAT      = 4'd15;

   // Register indexes on the configuration port
   localparam logic [IDX_BITS-1:0] CSR_MODE        = 3'd0;
   localparam logic [IDX_BITS-1:0] CSR_BLOCK_COUNT = 3'd1;
   localparam logic [IDX_BITS-1:0] CSR_KEY_A       = 3'd2;
   localparam logic [IDX_BITS-1:0] CSR_KEY_B       = 3'd3;
   localparam logic [IDX_BITS-1:0] CSR_KEY_C       = 3'd4;
   localparam logic [IDX_BITS-1:0] CSR_KEY_D       = 3'd5;

   // Result status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BAD_KEY = 2'd1;
   localparam logic [1:0] ST_SHORT   = 2'd2;

   typedef struct packed {
      logic [CHAR_BITS-1:0] char_in;
      logic                 msg_end;
   } req_payload_type;

   typedef struct packed {
      logic [CHAR_BITS-1:0] char_out;
      logic                 last;
      logic [1:0]           status;
   } rsp_payload_type;

   typedef struct packed {
      logic                               mode;
      logic [CNT_BITS-1:0]                block_count;
      logic [KEY_REGS-1:0][KEY_BITS-1:0]  key;
      logic                               key_ok;
   } cfg_type;

   // What an accepted character leads to
   typedef enum logic [1:0] {
      KIND_DROP,
      KIND_PUSH,
      KIND_BLOCK
   } dp_kind_type;

   typedef struct packed {
      logic accept;
      logic push_single;
      logic emit_step;
   } dp_cmd_type;

   typedef struct packed {
      dp_kind_type kind;
      logic        emit_final;
      logic        rsp_busy;
   } dp_stat_type;

   typedef enum logic {
      CS_ACCEPT,
      CS_EMIT
   } ctrl_state_type;

   // Entry of a key word at a slot (position minus one)
   function automatic logic [ENTRY_BITS-1:0] key_entry(input logic [KEY_BITS-1:0] word,
                                                       input logic [2:0] slot);
      logic [KEY_BITS-1:0] sh;
      sh = word >> (LEN_BITS + ENTRY_BITS * int'(slot));
      return sh[ENTRY_BITS-1:0];
   endfunction

endpackage

[rtl/block_transposition_cipher.sv]
// A result is registered by the transfer that causes it; the first character of a
// completed block passes the emission cursor registers and then the output register.
// One character per cycle is taken while a block fills and the output is free; then the
// block drains from its buffer, a position at a time, through the single output register.
// Reset (synchronous, active high) clears configuration, fill count, block index and
// the output valid; the block buffer holds no reset value.
module block_transposition_cipher (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  btc_pkg::req_payload_type       req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output btc_pkg::rsp_payload_type       rsp_data,
   input  logic                           csr_we,
   input  logic [btc_pkg::IDX_BITS-1:0]   csr_index,
   input  logic [btc_pkg::KEY_BITS-1:0]   csr_wdata
);

   btc_pkg::cfg_type     cfg;
   btc_pkg::dp_cmd_type  cmd;
   btc_pkg::dp_stat_type stat;

   btc_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   btc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   btc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

[rtl/btc_cfg.sv]
module btc_cfg (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [btc_pkg::IDX_BITS-1:0]   csr_index,
   input  logic [btc_pkg::KEY_BITS-1:0]   csr_wdata,
   output btc_pkg::cfg_type               cfg
);

   logic                                            mode_ff;
   logic [btc_pkg::CNT_BITS-1:0]                    count_ff;
   logic [btc_pkg::KEY_REGS-1:0][btc_pkg::KEY_BITS-1:0] key_ff;
   logic                                            key_ok;
   logic [btc_pkg::LEN_BITS-1:0]                    len;
   logic [btc_pkg::ENTRY_BITS-1:0]                  ent;

   // Take register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         count_ff <= '0;
         key_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            btc_pkg::CSR_MODE:        mode_ff   <= csr_wdata[0];
            btc_pkg::CSR_BLOCK_COUNT: count_ff  <= csr_wdata[btc_pkg::CNT_BITS-1:0];
            btc_pkg::CSR_KEY_A:       key_ff[0] <= csr_wdata;
            btc_pkg::CSR_KEY_B:       key_ff[1] <= csr_wdata;
            btc_pkg::CSR_KEY_C:       key_ff[2] <= csr_wdata;
            btc_pkg::CSR_KEY_D:       key_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Check the block count and that every block in use is a permutation of its positions
   always_comb begin
      key_ok = 1'b1;
      len    = '0;
      ent    = '0;
      if (count_ff > btc_pkg::MAX_BLOCKS) key_ok = 1'b0;
      for (int b = 0; b < btc_pkg::KEY_REGS; b++) begin
         if (btc_pkg::CNT_BITS'(b) < count_ff) begin
            len = key_ff[b][btc_pkg::LEN_BITS-1:0];
            if (len == '0 || len > btc_pkg::MAX_BLOCK_LEN) key_ok = 1'b0;
            for (int i = 0; i < btc_pkg::KEY_SLOTS; i++) begin
               if (btc_pkg::LEN_BITS'(i) < len) begin
                  ent = btc_pkg::key_entry(key_ff[b], 3'(i));
                  if ({1'b0, ent} >= len) key_ok = 1'b0;
                  for (int j = 0; j < i; j++) begin
                     if (btc_pkg::key_entry(key_ff[b], 3'(j)) == ent) key_ok = 1'b0;
                  end
               end
            end
         end
      end
   end

   assign cfg.mode        = mode_ff;
   assign cfg.block_count = count_ff;
   assign cfg.key         = key_ff;
   assign cfg.key_ok      = key_ok;

endmodule

[rtl/btc_datapath.sv]
module btc_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  btc_pkg::cfg_type          cfg,
   input  btc_pkg::dp_cmd_type       cmd,
   input  btc_pkg::req_payload_type  req_data,
   input  logic                      rsp_ready,
   output btc_pkg::dp_stat_type      stat,
   output logic                      rsp_valid,
   output btc_pkg::rsp_payload_type  rsp_data
);

   logic [btc_pkg::CHAR_BITS-1:0] buf_ff [btc_pkg::BUF_DEPTH];
   logic [btc_pkg::LEN_BITS-1:0]  fill_ff, fill_in, fill_next;
   logic [btc_pkg::CNT_BITS-1:0]  blk_ff, blk_in;
   logic [1:0]                    emit_blk_ff, emit_blk_in;
   logic [2:0]                    emit_pos_ff, emit_pos_in;
   logic [btc_pkg::LEN_BITS-1:0]  emit_len_ff, emit_len_in;
   logic                          emit_end_ff, emit_end_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   btc_pkg::rsp_payload_type      rsp_data_ff, rsp_data_in;

   btc_pkg::dp_kind_type          kind;
   btc_pkg::rsp_payload_type      single;
   btc_pkg::rsp_payload_type      emitted;
   logic [btc_pkg::LEN_BITS-1:0]  cur_len;
   logic                          in_span, last_block, complete, clear;
   logic [btc_pkg::KEY_BITS-1:0]  emit_word;
   logic [2:0]                    src, inv_src;
   logic                          emit_final;

   // Classify the character at the request port
   always_comb begin
      cur_len    = cfg.key[blk_ff[1:0]][btc_pkg::LEN_BITS-1:0];
      in_span    = blk_ff < cfg.block_count;
      last_block = ({1'b0, blk_ff} + 4'd1) == {1'b0, cfg.block_count};
      fill_next  = (fill_ff == btc_pkg::FILL_SAT) ? fill_ff : fill_ff + 4'd1;
      complete   = fill_next >= cur_len;
      kind       = btc_pkg::KIND_DROP;
      clear      = 1'b0;
      single     = '{char_out: '0, last: 1'b1, status: btc_pkg::ST_SHORT};
      if (!cfg.key_ok) begin
         single.status = btc_pkg::ST_BAD_KEY;
         if (req_data.msg_end) begin
            kind  = btc_pkg::KIND_PUSH;
            clear = 1'b1;
         end
      end else if (!in_span) begin
         kind   = btc_pkg::KIND_PUSH;
         clear  = req_data.msg_end;
         single = '{char_out: req_data.char_in, last: req_data.msg_end,
                    status: btc_pkg::ST_OK};
      end else if (!complete) begin
         if (req_data.msg_end) begin
            kind  = btc_pkg::KIND_PUSH;
            clear = 1'b1;
         end
      end else if (req_data.msg_end && !last_block) begin
         kind  = btc_pkg::KIND_PUSH;
         clear = 1'b1;
      end else begin
         kind = btc_pkg::KIND_BLOCK;
      end
   end

   // Pick the buffer slot for the current output position
   always_comb begin
      emit_word = cfg.key[emit_blk_ff];
      inv_src   = '0;
      for (int j = 0; j < btc_pkg::KEY_SLOTS; j++) begin
         if (btc_pkg::LEN_BITS'(j) < emit_len_ff &&
             btc_pkg::key_entry(emit_word, 3'(j)) == emit_pos_ff) begin
            inv_src = 3'(j);
         end
      end
      src        = cfg.mode ? inv_src : btc_pkg::key_entry(emit_word, emit_pos_ff);
      emit_final = ({1'b0, emit_pos_ff} + 4'd1) == emit_len_ff;
      emitted    = '{char_out: buf_ff[src], last: emit_end_ff && emit_final,
                     status: btc_pkg::ST_OK};
   end

   // Advance counters and the emission cursor
   always_comb begin
      fill_in     = fill_ff;
      blk_in      = blk_ff;
      emit_blk_in = emit_blk_ff;
      emit_pos_in = emit_pos_ff;
      emit_len_in = emit_len_ff;
      emit_end_in = emit_end_ff;
      if (cmd.accept) begin
         if (clear) begin
            fill_in = '0;
            blk_in  = '0;
         end else if (kind == btc_pkg::KIND_BLOCK) begin
            fill_in     = '0;
            blk_in      = req_data.msg_end ? '0 : blk_ff + 3'd1;
            emit_blk_in = blk_ff[1:0];
            emit_pos_in = '0;
            emit_len_in = cur_len;
            emit_end_in = req_data.msg_end;
         end else if (cfg.key_ok && in_span) begin
            fill_in = fill_next;
         end
      end else if (cmd.emit_step) begin
         emit_pos_in = emit_pos_ff + 3'd1;
      end
   end

   // Load the output register, drop it once the transfer completes
   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (cmd.push_single) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = single;
      end else if (cmd.emit_step) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emitted;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         blk_ff       <= '0;
         emit_pos_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         blk_ff       <= blk_in;
         emit_pos_ff  <= emit_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      emit_blk_ff <= emit_blk_in;
      emit_len_ff <= emit_len_in;
      emit_end_ff <= emit_end_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Store the character into the block buffer
   always_ff @(posedge clock) begin
      if (cmd.accept && cfg.key_ok && in_span && fill_ff < 4'(btc_pkg::BUF_DEPTH)) begin
         buf_ff[fill_ff[2:0]] <= req_data.char_in;
      end
   end

   assign stat.kind       = kind;
   assign stat.emit_final = emit_final;
   assign stat.rsp_busy   = rsp_valid_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

endmodule

[rtl/btc_ctrl.sv]
module btc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  rsp_ready,
   input  btc_pkg::dp_stat_type  stat,
   output logic                  req_ready,
   output btc_pkg::dp_cmd_type   cmd
);

   btc_pkg::ctrl_state_type state_ff, state_in;
   logic slot_free;

   assign slot_free = !stat.rsp_busy || rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         btc_pkg::CS_ACCEPT: begin
            if (req_valid && slot_free && stat.kind == btc_pkg::KIND_BLOCK) begin
               state_in = btc_pkg::CS_EMIT;
            end
         end
         btc_pkg::CS_EMIT: begin
            if (slot_free && stat.emit_final) state_in = btc_pkg::CS_ACCEPT;
         end
         default: state_in = btc_pkg::CS_ACCEPT;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready       = 1'b0;
      cmd.accept      = 1'b0;
      cmd.push_single = 1'b0;
      cmd.emit_step   = 1'b0;
      case (state_ff)
         btc_pkg::CS_ACCEPT: begin
            req_ready       = slot_free;
            cmd.accept      = req_valid && slot_free;
            cmd.push_single = req_valid && slot_free && stat.kind == btc_pkg::KIND_PUSH;
         end
         btc_pkg::CS_EMIT: begin
            cmd.emit_step = slot_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= btc_pkg::CS_ACCEPT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/btc_checker.sv]
module btc_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input btc_pkg::rsp_payload_type  rsp_data
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Take a character only when the output register can take its result
   a_ready_slot: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid || rsp_ready)
      else $error("request ready while output register is blocked");

   // Status results carry no character and close the message
   a_status_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != btc_pkg::ST_OK |->
         rsp_data.char_out == '0 && rsp_data.last)
      else $error("malformed status result");

   // Never show an unused status code
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status == btc_pkg::ST_OK ||
                    rsp_data.status == btc_pkg::ST_BAD_KEY ||
                    rsp_data.status == btc_pkg::ST_SHORT)
      else $error("unknown status code");

   // Come out of reset with no result pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind block_transposition_cipher btc_checker u_btc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
